// ----- src/twpc_pkg.sv -----
// Package for the ternary word prefix-code bit packer.
// Holds sizes, input mode codes and the command type passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twpc_pkg;

	localparam int TABLE_DEPTH  = 128;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int EFF_MAX_LEN  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int WORD_W       = 7;
	localparam int BYTE_W       = 8;
	localparam int WL_W         = 3;
	localparam int WL_MIN       = 1;
	localparam int WL_MAX       = 4;
	localparam int WL_RESET     = 2;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_LETTER = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	localparam logic [1:0] LETTER_C = 2'd2;

	typedef struct packed {
		logic              is_flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

`default_nettype wire

// ----- src/twpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module twpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/twpc_front.sv -----
// Front end: accepts items, builds base-3 words, owns the code table and
// issues word and flush commands. Depends on twpc_pkg and twpc_ram.
`timescale 1ns / 1ps
`default_nettype none

module twpc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   mode,
	input  wire logic [6:0]                   entry_index,
	input  wire logic [twpc_pkg::CODE_W-1:0]  code_bits,
	input  wire logic [twpc_pkg::LEN_W-1:0]   code_length,
	input  wire logic [1:0]                   letter,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [twpc_pkg::WL_W-1:0]    cfg_data,
	output logic                              cmd_valid,
	input  wire logic                         cmd_ready,
	output twpc_pkg::cmd_t                    cmd
);

	localparam int RAM_W = twpc_pkg::LEN_W + twpc_pkg::CODE_W;

	logic [twpc_pkg::WL_W-1:0]   wl_q;
	logic [twpc_pkg::WORD_W-1:0] wv_q;
	logic [twpc_pkg::WL_W-1:0]   lc_q;
	logic                        s1_v_q;
	logic                        s1_flush_q;
	logic                        s1_ok_q;

	logic                        accept;
	logic                        cfg_acc;
	logic                        is_letter;
	logic                        is_flush;
	logic [1:0]                  letter_eff;
	logic [twpc_pkg::WORD_W+1:0] wv_x3;
	logic [twpc_pkg::WORD_W-1:0] wv_next;
	logic [twpc_pkg::WL_W-1:0]   lc_next;
	logic [twpc_pkg::WL_W-1:0]   eff_wl;
	logic                        word_done;
	logic                        idx_ok;
	logic [twpc_pkg::LEN_W-1:0]  len_c;
	logic                        ram_we;
	logic                        ram_re;
	logic [RAM_W-1:0]            ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_ready  = !s1_v_q || cmd_ready;
	assign accept    = in_valid & in_ready;
	assign is_letter = (mode == twpc_pkg::MODE_LETTER);
	assign is_flush  = (mode == twpc_pkg::MODE_FLUSH);

	always_comb begin
		letter_eff = (letter > twpc_pkg::LETTER_C) ? twpc_pkg::LETTER_C : letter;
		wv_x3      = {2'b00, wv_q} + {1'b0, wv_q, 1'b0} + {7'd0, letter_eff};
		wv_next    = wv_x3[twpc_pkg::WORD_W-1:0];
		lc_next    = lc_q + 3'd1;
		if (wl_q < twpc_pkg::WL_W'(twpc_pkg::WL_MIN)) begin
			eff_wl = twpc_pkg::WL_W'(twpc_pkg::WL_MIN);
		end else if (wl_q > twpc_pkg::WL_W'(twpc_pkg::WL_MAX)) begin
			eff_wl = twpc_pkg::WL_W'(twpc_pkg::WL_MAX);
		end else begin
			eff_wl = wl_q;
		end
		word_done = is_letter && (lc_next >= eff_wl);
		idx_ok    = (32'(wv_next) < twpc_pkg::TABLE_DEPTH);
		if (code_length > twpc_pkg::LEN_W'(twpc_pkg::EFF_MAX_LEN)) begin
			len_c = twpc_pkg::LEN_W'(twpc_pkg::EFF_MAX_LEN);
		end else begin
			len_c = code_length;
		end
	end

	assign ram_we = accept && (mode == twpc_pkg::MODE_WRITE) &&
		(32'(entry_index) < twpc_pkg::TABLE_DEPTH);
	assign ram_re = accept && word_done;

	twpc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (twpc_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (twpc_pkg::ADDR_W'(entry_index)),
		.wdata ({len_c, code_bits}),
		.re    (ram_re),
		.raddr (twpc_pkg::ADDR_W'(wv_next)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q       <= twpc_pkg::WL_W'(twpc_pkg::WL_RESET);
			wv_q       <= '0;
			lc_q       <= '0;
			s1_v_q     <= 1'b0;
			s1_flush_q <= 1'b0;
			s1_ok_q    <= 1'b0;
		end else begin
			if (cfg_acc) begin
				wl_q <= cfg_data;
			end
			// a register write drops the partial word
			if (cfg_acc) begin
				wv_q <= '0;
				lc_q <= '0;
			end else if (accept && is_letter) begin
				wv_q <= word_done ? '0 : wv_next;
				lc_q <= word_done ? '0 : lc_next;
			end else if (accept && is_flush) begin
				wv_q <= '0;
				lc_q <= '0;
			end
			if (accept && (word_done || is_flush)) begin
				s1_v_q     <= 1'b1;
				s1_flush_q <= is_flush;
				s1_ok_q    <= idx_ok;
			end else if (cmd_ready) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	assign cmd_valid    = s1_v_q;
	assign cmd.is_flush = s1_flush_q;
	assign cmd.code     = ram_rdata[twpc_pkg::CODE_W-1:0];
	assign cmd.len      = (s1_flush_q || !s1_ok_q) ? '0 : ram_rdata[RAM_W-1:twpc_pkg::CODE_W];

endmodule

`default_nettype wire

// ----- src/twpc_queue.sv -----
// Short command queue between front and back end.
// Depends on twpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twpc_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire twpc_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output twpc_pkg::cmd_t pop_cmd
);

	twpc_pkg::cmd_t                ent_q [twpc_pkg::QDEPTH];
	logic [twpc_pkg::QPTR_W-1:0]   wr_q;
	logic [twpc_pkg::QPTR_W-1:0]   rd_q;
	logic [twpc_pkg::QCNT_W-1:0]   cnt_q;
	logic                          push;
	logic                          pop;

	assign push_ready = (cnt_q != twpc_pkg::QCNT_W'(twpc_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;
	assign pop_cmd    = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == twpc_pkg::QPTR_W'(twpc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == twpc_pkg::QPTR_W'(twpc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/twpc_back.sv -----
// Back end: shifts code bits MSB-first into the byte accumulator, up to one
// byte per cycle unless stalled; drives the output register. Depends on twpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twpc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	output logic                           cmd_ready,
	input  wire twpc_pkg::cmd_t            cmd,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [twpc_pkg::BYTE_W-1:0]    out_byte,
	output logic                           last
);

	logic                          busy_q;
	logic [twpc_pkg::CODE_W-1:0]   sh_q;
	logic [twpc_pkg::LEN_W-1:0]    rem_q;
	logic [twpc_pkg::BYTE_W-2:0]   acc_q;
	logic [2:0]                    cnt_q;
	logic                          out_v_q;
	logic [twpc_pkg::BYTE_W-1:0]   byte_q;
	logic                          last_q;

	logic                          can_emit;
	logic                          pop;
	logic [3:0]                    avail;
	logic [3:0]                    k;
	logic [3:0]                    sum;
	logic                          step_emit;
	logic                          step_go;
	logic [twpc_pkg::BYTE_W-1:0]   chunk;
	logic [twpc_pkg::BYTE_W-1:0]   acc_next;
	logic [twpc_pkg::LEN_W-1:0]    rem_next;
	logic [twpc_pkg::BYTE_W-1:0]   flush_byte;

	assign can_emit  = !out_v_q || out_ready;
	assign cmd_ready = !busy_q && (!cmd.is_flush || (cnt_q == 3'd0) || can_emit);
	assign pop       = cmd_valid & cmd_ready;

	always_comb begin
		avail = 4'(twpc_pkg::BYTE_W) - {1'b0, cnt_q};
		if (rem_q < {2'b00, avail}) begin
			k = rem_q[3:0];
		end else begin
			k = avail;
		end
		sum        = {1'b0, cnt_q} + k;
		step_emit  = (sum == 4'(twpc_pkg::BYTE_W));
		step_go    = busy_q && (!step_emit || can_emit);
		chunk      = sh_q[twpc_pkg::CODE_W-1 -: twpc_pkg::BYTE_W] >>
			(4'(twpc_pkg::BYTE_W) - k);
		acc_next   = ({1'b0, acc_q} << k) | chunk;
		rem_next   = rem_q - {2'b00, k};
		flush_byte = {1'b0, acc_q} << (4'(twpc_pkg::BYTE_W) - {1'b0, cnt_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rem_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && cmd.is_flush) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (pop) begin
				busy_q <= (cmd.len != '0);
				rem_q  <= cmd.len;
			end else if (step_go) begin
				busy_q <= (rem_next != '0);
				rem_q  <= rem_next;
				acc_q  <= step_emit ? '0 : acc_next[twpc_pkg::BYTE_W-2:0];
				cnt_q  <= step_emit ? 3'd0 : sum[2:0];
			end
			if (pop && cmd.is_flush && (cnt_q != 3'd0)) begin
				out_v_q <= 1'b1;
			end else if (step_go && step_emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload side: left-align the code on load, then shift out k bits a step
	always_ff @(posedge clk) begin
		if (pop && !cmd.is_flush) begin
			sh_q <= cmd.code << (twpc_pkg::LEN_W'(twpc_pkg::CODE_W) - cmd.len);
		end else if (step_go) begin
			sh_q <= sh_q << k;
		end
		if (pop && cmd.is_flush && (cnt_q != 3'd0)) begin
			byte_q <= flush_byte;
			last_q <= 1'b1;
		end else if (step_go && step_emit) begin
			byte_q <= acc_next;
			// last when what remains cannot fill another byte
			last_q <= (rem_next < twpc_pkg::LEN_W'(twpc_pkg::BYTE_W));
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0) && (rem_q <= twpc_pkg::LEN_W'(twpc_pkg::EFF_MAX_LEN)))
		else $error("busy with no pending code bits");
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && step_emit) |=> (out_v_q && (cnt_q == 3'd0)))
		else $error("completed byte not presented");
	a_flush_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.is_flush) |=> ((cnt_q == 3'd0) && !busy_q))
		else $error("flush left bits pending");
`endif

endmodule

`default_nettype wire

// ----- src/ternary_word_prefix_code_bit_packer.sv -----
// Ternary word prefix-code bit packer, top level. Depends on twpc_pkg and the twpc modules.
// Front takes one item per cycle while the queue has room; table lookups are registered.
// Word bytes pass front register, queue, back-end load and packing; a flush skips packing.
// Back end loads a word from the queue, then packs up to 8 bits per cycle unless the
// output stalls; it takes no new command until the code bits of the word are packed.
// Reset clears word and bit state and sets word_length to 2; the table is unset until written.
`timescale 1ns / 1ps
`default_nettype none

module ternary_word_prefix_code_bit_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [6:0]  entry_index,
	input  wire logic [31:0] code_bits,
	input  wire logic [5:0]  code_length,
	input  wire logic [1:0]  letter,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic           f_valid;
	logic           f_ready;
	twpc_pkg::cmd_t f_cmd;
	logic           b_valid;
	logic           b_ready;
	twpc_pkg::cmd_t b_cmd;

	twpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.entry_index (entry_index),
		.code_bits   (code_bits),
		.code_length (code_length),
		.letter      (letter),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	twpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	twpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

`default_nettype wire
